FILE: hw/rtl/canopen_rx_feedback_demux_defines.svh
// ---------------------------------------------------------------------------
// canopen_rx_feedback_demux_defines.svh
// Assertion macros for the CANopen receive demux. Define ASSERT_OFF to drop
// every check from the build.
// ---------------------------------------------------------------------------
`ifndef CANOPEN_RX_FEEDBACK_DEMUX_DEFINES_SVH
`define CANOPEN_RX_FEEDBACK_DEMUX_DEFINES_SVH

`ifndef ASSERT_OFF
// Check a property on clk, ignored while rst_n is low
`define CRFD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check a property on clk, also while rst_n is low
`define CRFD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define CRFD_ASSERT(lbl, prop, msg)
`define CRFD_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

FILE: hw/rtl/crfd_pkg.sv
// ---------------------------------------------------------------------------
// crfd_pkg
// Types and constants shared by the CANopen receive demux and its channels.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package crfd_pkg;

  localparam int unsigned NODE_W   = 7;
  localparam int unsigned ID_W     = 11;
  localparam int unsigned DLC_W    = 4;
  localparam int unsigned CFG_IDX_W = 1;

  // Function code bases of the predefined connection set
  localparam logic [ID_W-1:0] BASE_EMCY  = 11'h080;
  localparam logic [ID_W-1:0] BASE_TPDO1 = 11'h180;
  localparam logic [ID_W-1:0] BASE_TPDO2 = 11'h280;
  localparam logic [ID_W-1:0] BASE_HB    = 11'h700;

  // Shortest frame that each kind needs
  localparam logic [DLC_W-1:0] DLC_MIN_HB    = 4'd1;
  localparam logic [DLC_W-1:0] DLC_MIN_TPDO1 = 4'd8;
  localparam logic [DLC_W-1:0] DLC_MIN_TPDO2 = 4'd2;
  localparam logic [DLC_W-1:0] DLC_MIN_EMCY  = 4'd8;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LEFT_NODE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_NODE = 1'd1;

  localparam logic [NODE_W-1:0] LEFT_NODE_RST  = 7'd1;
  localparam logic [NODE_W-1:0] RIGHT_NODE_RST = 7'd2;

  // Seen flag bit positions
  localparam int unsigned SEEN_HB   = 0;
  localparam int unsigned SEEN_PDO1 = 1;
  localparam int unsigned SEEN_PDO2 = 2;
  localparam int unsigned SEEN_EMCY = 3;

  typedef enum logic [2:0] {
    KIND_NONE  = 3'd0,
    KIND_HB    = 3'd1,
    KIND_TPDO1 = 3'd2,
    KIND_TPDO2 = 3'd3,
    KIND_EMCY  = 3'd4
  } kind_t;

  typedef enum logic {
    SIDE_LEFT  = 1'b0,
    SIDE_RIGHT = 1'b1
  } side_t;

  typedef struct packed {
    logic             extended;
    logic [ID_W-1:0]  frame_id;
    logic [DLC_W-1:0] dlc;
    logic [31:0]      payload_lo;
    logic [31:0]      payload_hi;
  } frame_t;

  typedef struct packed {
    logic [3:0]          seen_flags;
    logic [7:0]          nmt_state;
    logic signed [31:0]  speed;
    logic signed [31:0]  position;
    logic signed [15:0]  current;
    logic [15:0]         err_code;
    logic [7:0]          err_register;
    logic [39:0]         err_data;
  } node_rec_t;

  typedef struct packed {
    logic      accepted;
    side_t     node_side;
    kind_t     kind;
    node_rec_t rec;
  } result_t;

endpackage

`default_nettype wire

FILE: hw/rtl/crfd_frame_if.sv
// ---------------------------------------------------------------------------
// crfd_frame_if
// Valid/ready channel that carries one received CAN frame per transfer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface crfd_frame_if;
  logic                           valid;
  logic                           ready;
  logic                           extended;
  logic [crfd_pkg::ID_W-1:0]      frame_id;
  logic [crfd_pkg::DLC_W-1:0]     dlc;
  logic [31:0]                    payload_lo;
  logic [31:0]                    payload_hi;

  modport source (
    output valid, extended, frame_id, dlc, payload_lo, payload_hi,
    input  ready
  );

  modport sink (
    input  valid, extended, frame_id, dlc, payload_lo, payload_hi,
    output ready
  );
endinterface

`default_nettype wire

FILE: hw/rtl/crfd_fb_if.sv
// ---------------------------------------------------------------------------
// crfd_fb_if
// Valid/ready channel that carries one node feedback result per transfer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface crfd_fb_if;
  logic               valid;
  logic               ready;
  logic               accepted;
  logic               node_side;
  logic [2:0]         kind;
  logic [3:0]         seen_flags;
  logic [7:0]         nmt_state;
  logic signed [31:0] speed;
  logic signed [31:0] position;
  logic signed [15:0] current;
  logic [15:0]        err_code;
  logic [7:0]         err_register;
  logic [39:0]        err_data;

  modport source (
    output valid, accepted, node_side, kind, seen_flags, nmt_state, speed,
           position, current, err_code, err_register, err_data,
    input  ready
  );

  modport sink (
    input  valid, accepted, node_side, kind, seen_flags, nmt_state, speed,
           position, current, err_code, err_register, err_data,
    output ready
  );
endinterface

`default_nettype wire

FILE: hw/rtl/canopen_rx_feedback_demux.sv
// ---------------------------------------------------------------------------
// canopen_rx_feedback_demux
// Sorts received CAN frames into heartbeat, TPDO1, TPDO2 and EMCY updates for
// two configured CANopen nodes and reports the updated node record.
// ---------------------------------------------------------------------------
//  channel   | dir | transfer                 | payload
//  in_frame  | in  | valid & ready            | extended, frame_id, dlc, payload
//  out_fb    | out | valid & ready            | accepted, side, kind, record
//  cfg_*     | in  | cfg_we (no handshake)    | cfg_index, cfg_wdata
//
//  One frame per cycle sustained while out_fb is ready; a frame's result shows
//  on out_fb after its transfer, through the input register, then the result register.
//  Record update and result are formed combinationally from the input register.
//  While a result waits, the input register takes one frame only if it is empty.
//  Synchronous active-low reset clears node records and restores node ids.
//  Stalls on out_fb back up into the input register, then into in_frame.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "canopen_rx_feedback_demux_defines.svh"

module canopen_rx_feedback_demux (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  crfd_frame_if.sink                            in_frame,
  crfd_fb_if.source                             out_fb,
  input  wire logic                             cfg_we,
  input  wire logic [crfd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [crfd_pkg::NODE_W-1:0]      cfg_wdata
);

  // Node id registers
  logic [crfd_pkg::NODE_W-1:0] left_node_r, left_node_nxt;
  logic [crfd_pkg::NODE_W-1:0] right_node_r, right_node_nxt;

  // Input register
  logic              s1_valid_r, s1_valid_nxt;
  crfd_pkg::frame_t  s1_frame_r;

  // Node records, index by side
  crfd_pkg::node_rec_t rec_r [2];

  // Result register
  logic               out_valid_r, out_valid_nxt;
  crfd_pkg::result_t  out_res_r;

  // Handshake
  logic in_fire;
  logic in_ready;
  logic out_fire;
  logic s1_adv;

  // Decode
  logic                hb_left, hb_right, p1_left, p1_right;
  logic                p2_left, p2_right, em_left, em_right;
  crfd_pkg::kind_t     kind;
  crfd_pkg::side_t     side;
  crfd_pkg::node_rec_t rec_sel;
  crfd_pkg::node_rec_t rec_upd;
  crfd_pkg::result_t   res_nxt;

  function automatic logic id_match(
    input logic [crfd_pkg::ID_W-1:0]   id,
    input logic [crfd_pkg::ID_W-1:0]   base,
    input logic [crfd_pkg::NODE_W-1:0] node
  );
    logic [crfd_pkg::ID_W-1:0] want;
    want = base + {{(crfd_pkg::ID_W - crfd_pkg::NODE_W){1'b0}}, node};
    return id == want;
  endfunction

  // Handshake and pipeline advance
  assign s1_adv    = s1_valid_r && (!out_valid_r || out_fb.ready);
  assign in_ready  = !s1_valid_r || s1_adv;
  assign in_fire   = in_frame.valid && in_ready;
  assign out_fire  = out_valid_r && out_fb.ready;
  assign in_frame.ready = in_ready;

  // Configuration writes
  always_comb begin
    left_node_nxt  = left_node_r;
    right_node_nxt = right_node_r;
    if (cfg_we) begin
      case (cfg_index)
        crfd_pkg::CFG_LEFT_NODE:  left_node_nxt  = cfg_wdata;
        crfd_pkg::CFG_RIGHT_NODE: right_node_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  // Identifier matches per kind and side
  always_comb begin
    hb_left  = id_match(s1_frame_r.frame_id, crfd_pkg::BASE_HB,    left_node_r);
    hb_right = id_match(s1_frame_r.frame_id, crfd_pkg::BASE_HB,    right_node_r);
    p1_left  = id_match(s1_frame_r.frame_id, crfd_pkg::BASE_TPDO1, left_node_r);
    p1_right = id_match(s1_frame_r.frame_id, crfd_pkg::BASE_TPDO1, right_node_r);
    p2_left  = id_match(s1_frame_r.frame_id, crfd_pkg::BASE_TPDO2, left_node_r);
    p2_right = id_match(s1_frame_r.frame_id, crfd_pkg::BASE_TPDO2, right_node_r);
    em_left  = id_match(s1_frame_r.frame_id, crfd_pkg::BASE_EMCY,  left_node_r);
    em_right = id_match(s1_frame_r.frame_id, crfd_pkg::BASE_EMCY,  right_node_r);
  end

  // Pick kind and side in priority order, left before right
  always_comb begin
    kind = crfd_pkg::KIND_NONE;
    side = crfd_pkg::SIDE_LEFT;
    if (!s1_frame_r.extended) begin
      if ((hb_left || hb_right) && s1_frame_r.dlc >= crfd_pkg::DLC_MIN_HB) begin
        kind = crfd_pkg::KIND_HB;
        side = hb_left ? crfd_pkg::SIDE_LEFT : crfd_pkg::SIDE_RIGHT;
      end else if ((p1_left || p1_right) &&
                   s1_frame_r.dlc >= crfd_pkg::DLC_MIN_TPDO1) begin
        kind = crfd_pkg::KIND_TPDO1;
        side = p1_left ? crfd_pkg::SIDE_LEFT : crfd_pkg::SIDE_RIGHT;
      end else if ((p2_left || p2_right) &&
                   s1_frame_r.dlc >= crfd_pkg::DLC_MIN_TPDO2) begin
        kind = crfd_pkg::KIND_TPDO2;
        side = p2_left ? crfd_pkg::SIDE_LEFT : crfd_pkg::SIDE_RIGHT;
      end else if ((em_left || em_right) &&
                   s1_frame_r.dlc >= crfd_pkg::DLC_MIN_EMCY) begin
        kind = crfd_pkg::KIND_EMCY;
        side = em_left ? crfd_pkg::SIDE_LEFT : crfd_pkg::SIDE_RIGHT;
      end
    end
  end

  // Build the updated record of the chosen node
  always_comb begin
    rec_sel = rec_r[side];
    rec_upd = rec_sel;
    case (kind)
      crfd_pkg::KIND_HB: begin
        rec_upd.seen_flags[crfd_pkg::SEEN_HB] = 1'b1;
        rec_upd.nmt_state = s1_frame_r.payload_lo[7:0];
      end
      crfd_pkg::KIND_TPDO1: begin
        rec_upd.seen_flags[crfd_pkg::SEEN_PDO1] = 1'b1;
        rec_upd.speed    = s1_frame_r.payload_lo;
        rec_upd.position = s1_frame_r.payload_hi;
      end
      crfd_pkg::KIND_TPDO2: begin
        rec_upd.seen_flags[crfd_pkg::SEEN_PDO2] = 1'b1;
        rec_upd.current = s1_frame_r.payload_lo[15:0];
      end
      crfd_pkg::KIND_EMCY: begin
        rec_upd.seen_flags[crfd_pkg::SEEN_EMCY] = 1'b1;
        rec_upd.err_code     = s1_frame_r.payload_lo[15:0];
        rec_upd.err_register = s1_frame_r.payload_lo[23:16];
        rec_upd.err_data     = {s1_frame_r.payload_hi, s1_frame_r.payload_lo[31:24]};
      end
      default: ;
    endcase
  end

  // Result: all zero when no record changed
  always_comb begin
    res_nxt = '0;
    if (kind != crfd_pkg::KIND_NONE) begin
      res_nxt.accepted  = 1'b1;
      res_nxt.node_side = side;
      res_nxt.kind      = kind;
      res_nxt.rec       = rec_upd;
    end
  end

  // Valid bits of both stages
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_fire) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control state and node records
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_node_r  <= crfd_pkg::LEFT_NODE_RST;
      right_node_r <= crfd_pkg::RIGHT_NODE_RST;
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      rec_r[0]     <= '0;
      rec_r[1]     <= '0;
    end else begin
      left_node_r  <= left_node_nxt;
      right_node_r <= right_node_nxt;
      s1_valid_r   <= s1_valid_nxt;
      out_valid_r  <= out_valid_nxt;
      if (s1_adv && kind != crfd_pkg::KIND_NONE) begin
        rec_r[side] <= rec_upd;
      end
    end
  end

  // Capture the frame and the result
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_frame_r.extended   <= in_frame.extended;
      s1_frame_r.frame_id   <= in_frame.frame_id;
      s1_frame_r.dlc        <= in_frame.dlc;
      s1_frame_r.payload_lo <= in_frame.payload_lo;
      s1_frame_r.payload_hi <= in_frame.payload_hi;
    end
    if (s1_adv) begin
      out_res_r <= res_nxt;
    end
  end

  // Drive the result channel
  assign out_fb.valid        = out_valid_r;
  assign out_fb.accepted     = out_res_r.accepted;
  assign out_fb.node_side    = out_res_r.node_side;
  assign out_fb.kind         = out_res_r.kind;
  assign out_fb.seen_flags   = out_res_r.rec.seen_flags;
  assign out_fb.nmt_state    = out_res_r.rec.nmt_state;
  assign out_fb.speed        = out_res_r.rec.speed;
  assign out_fb.position     = out_res_r.rec.position;
  assign out_fb.current      = out_res_r.rec.current;
  assign out_fb.err_code     = out_res_r.rec.err_code;
  assign out_fb.err_register = out_res_r.rec.err_register;
  assign out_fb.err_data     = out_res_r.rec.err_data;

  // Checks
  `CRFD_ASSERT(a_acc_kind, out_valid_r |-> (out_res_r.accepted == (out_res_r.kind != crfd_pkg::KIND_NONE)), "accepted flag disagrees with kind")
  `CRFD_ASSERT(a_hb_seen, (out_valid_r && out_res_r.kind == crfd_pkg::KIND_HB) |-> out_res_r.rec.seen_flags[crfd_pkg::SEEN_HB], "heartbeat result without heartbeat seen")
  `CRFD_ASSERT(a_adv_out, (s1_valid_r && s1_adv) |=> out_valid_r, "advanced frame produced no result")
  `CRFD_ASSERT(a_seen_sticky, rec_r[0].seen_flags[crfd_pkg::SEEN_HB] |=> rec_r[0].seen_flags[crfd_pkg::SEEN_HB], "left heartbeat seen flag cleared")
  `CRFD_ASSERT_ALWAYS(a_empty_ready, (rst_n && !s1_valid_r) |-> in_ready, "input stalled with empty input register")

endmodule

`default_nettype wire
